### rtl/bfb_pkg.sv
// ----------------------------------------------------------------------------
// bfb_pkg
// request and status codes and the control word that travels along the
// bin cell chain
// ----------------------------------------------------------------------------
package bfb_pkg;

    localparam logic [2:0] REQ_LOAD   = 3'd0;
    localparam logic [2:0] REQ_UPDATE = 3'd1;
    localparam logic [2:0] REQ_MOST   = 3'd2;
    localparam logic [2:0] REQ_BEST   = 3'd3;
    localparam logic [2:0] REQ_READ   = 3'd4;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_NONE = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;
    localparam logic [1:0] ST_ZERO = 2'd3;

    typedef struct packed {
        logic       valid;
        logic [2:0] op;
        logic       excl;
        logic       found;
        logic       do_load;
        logic [1:0] status;
    } tok_ctrl_t;

endpackage

### rtl/bfb_req_if.sv
// ----------------------------------------------------------------------------
// bfb_req_if
// request channel: valid, ready and the request item
// ----------------------------------------------------------------------------
interface bfb_req_if #(
    parameter int ID_BITS     = 16,
    parameter int VOLUME_BITS = 24
) ();
    logic                   valid;
    logic                   ready;
    logic [2:0]             req_type;
    logic [ID_BITS-1:0]     box_id;
    logic [VOLUME_BITS-1:0] volume;
    logic                   exclude_enable;

    modport source (
        output valid, req_type, box_id, volume, exclude_enable,
        input  ready
    );

    modport sink (
        input  valid, req_type, box_id, volume, exclude_enable,
        output ready
    );
endinterface

### rtl/bfb_rsp_if.sv
// ----------------------------------------------------------------------------
// bfb_rsp_if
// response channel: valid, ready and the result item
// ----------------------------------------------------------------------------
interface bfb_rsp_if #(
    parameter int ID_BITS     = 16,
    parameter int VOLUME_BITS = 24
) ();
    logic                   valid;
    logic                   ready;
    logic [1:0]             status;
    logic [ID_BITS-1:0]     result_id;
    logic [VOLUME_BITS-1:0] result_volume;
    logic                   notify_store;

    modport source (
        output valid, status, result_id, result_volume, notify_store,
        input  ready
    );

    modport sink (
        input  valid, status, result_id, result_volume, notify_store,
        output ready
    );
endinterface

### rtl/bfb_cell.sv
// ----------------------------------------------------------------------------
// bfb_cell
// one table slot: holds a bin id and volume, applies the passing request
// to its slot and hands the running best on to the next cell
// ----------------------------------------------------------------------------
module bfb_cell
    import bfb_pkg::*;
#(
    parameter int ID_BITS     = 16,
    parameter int VOLUME_BITS = 24,
    parameter int CNT_W       = 7,
    parameter int CELL_INDEX  = 0
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [CNT_W-1:0]       bin_count,
    input  logic [ID_BITS-1:0]     key_id,
    input  logic [VOLUME_BITS-1:0] key_vol,
    input  tok_ctrl_t              ctrl_in,
    input  logic [ID_BITS-1:0]     best_id_in,
    input  logic [VOLUME_BITS-1:0] best_vol_in,
    output tok_ctrl_t              ctrl_out,
    output logic [ID_BITS-1:0]     best_id_out,
    output logic [VOLUME_BITS-1:0] best_vol_out
);

    localparam logic [CNT_W-1:0] MY_INDEX = CNT_W'(CELL_INDEX);

    logic [ID_BITS-1:0]     id_reg, id_next;
    logic [VOLUME_BITS-1:0] vol_reg, vol_next;
    tok_ctrl_t              ctrl_reg, ctrl_next;
    logic [ID_BITS-1:0]     best_id_reg, best_id_next;
    logic [VOLUME_BITS-1:0] best_vol_reg, best_vol_next;

    logic in_use;
    logic id_hit;
    logic take;

    always_comb
    begin
        in_use        = (MY_INDEX < bin_count);
        id_hit        = (id_reg == key_id);
        take          = 1'b0;
        id_next       = id_reg;
        vol_next      = vol_reg;
        ctrl_next     = ctrl_in;
        best_id_next  = best_id_in;
        best_vol_next = best_vol_in;

        if (ctrl_in.valid)
        begin
            case (ctrl_in.op)
                REQ_LOAD:
                begin
                    if (ctrl_in.do_load && (MY_INDEX == bin_count))
                    begin
                        id_next  = key_id;
                        vol_next = key_vol;
                    end
                end
                REQ_UPDATE:
                begin
                    if (in_use && !ctrl_in.found && id_hit)
                    begin
                        vol_next        = key_vol;
                        ctrl_next.found = 1'b1;
                    end
                end
                REQ_READ:
                begin
                    take = in_use && !ctrl_in.found && id_hit;
                end
                REQ_MOST:
                begin
                    take = in_use && (!ctrl_in.found || (vol_reg > best_vol_in));
                end
                REQ_BEST:
                begin
                    take = in_use && !(ctrl_in.excl && id_hit) && (vol_reg > key_vol)
                           && (!ctrl_in.found || (vol_reg < best_vol_in));
                end
                default:
                begin
                    take = 1'b0;
                end
            endcase
        end

        if (take)
        begin
            ctrl_next.found = 1'b1;
            best_id_next    = id_reg;
            best_vol_next   = vol_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg <= '0;
        end
        else
        begin
            ctrl_reg <= ctrl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        id_reg       <= id_next;
        vol_reg      <= vol_next;
        best_id_reg  <= best_id_next;
        best_vol_reg <= best_vol_next;
    end

    assign ctrl_out     = ctrl_reg;
    assign best_id_out  = best_id_reg;
    assign best_vol_out = best_vol_reg;

endmodule

### rtl/best_fit_bin_table.sv
// ----------------------------------------------------------------------------
// best_fit_bin_table
// path: an accepted request is registered as a token in the launch register,
//   walks the chain of TABLE_DEPTH bin cells one cell per cycle, and its result
//   is registered in the output register; request ready stays low until then
// a finished result waits in a hold register while the output is stalled
// reset: bin count and all handshake state clear at once, bin slots undefined
// ----------------------------------------------------------------------------
module best_fit_bin_table
    import bfb_pkg::*;
#(
    parameter int TABLE_DEPTH = 64,
    parameter int ID_BITS     = 16,
    parameter int VOLUME_BITS = 24
) (
    input  logic      clk,
    input  logic      rst_n,
    bfb_req_if.sink   req_ch,
    bfb_rsp_if.source rsp_ch
);

    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(TABLE_DEPTH);

    logic [CNT_W-1:0]       bin_count_reg, bin_count_next;
    logic                   busy_reg, busy_next;
    logic [ID_BITS-1:0]     key_id_reg, key_id_next;
    logic [VOLUME_BITS-1:0] key_vol_reg, key_vol_next;
    tok_ctrl_t              launch_reg, launch_next;

    logic                   hold_valid_reg, hold_valid_next;
    logic [1:0]             hold_status_reg, hold_status_next;
    logic [ID_BITS-1:0]     hold_id_reg, hold_id_next;
    logic [VOLUME_BITS-1:0] hold_vol_reg, hold_vol_next;
    logic                   hold_notify_reg, hold_notify_next;

    logic                   out_valid_reg, out_valid_next;
    logic [1:0]             out_status_reg, out_status_next;
    logic [ID_BITS-1:0]     out_id_reg, out_id_next;
    logic [VOLUME_BITS-1:0] out_vol_reg, out_vol_next;
    logic                   out_notify_reg, out_notify_next;

    tok_ctrl_t              tok_ctrl [0:TABLE_DEPTH];
    logic [ID_BITS-1:0]     tok_id   [0:TABLE_DEPTH];
    logic [VOLUME_BITS-1:0] tok_vol  [0:TABLE_DEPTH];

    logic                   req_accept;
    logic                   out_free;
    tok_ctrl_t              fin;
    logic [1:0]             fin_status;
    logic [ID_BITS-1:0]     fin_id;
    logic [VOLUME_BITS-1:0] fin_vol;
    logic                   fin_notify;

    assign req_ch.ready = !busy_reg;
    assign req_accept   = req_ch.valid && !busy_reg;
    assign out_free     = !out_valid_reg || rsp_ch.ready;

    assign tok_ctrl[0] = launch_reg;
    assign tok_id[0]   = '0;
    assign tok_vol[0]  = '0;

    genvar gi;
    generate
        for (gi = 0; gi < TABLE_DEPTH; gi++)
        begin : g_cell
            bfb_cell #(
                .ID_BITS     (ID_BITS),
                .VOLUME_BITS (VOLUME_BITS),
                .CNT_W       (CNT_W),
                .CELL_INDEX  (gi)
            ) u_cell (
                .clk          (clk),
                .rst_n        (rst_n),
                .bin_count    (bin_count_reg),
                .key_id       (key_id_reg),
                .key_vol      (key_vol_reg),
                .ctrl_in      (tok_ctrl[gi]),
                .best_id_in   (tok_id[gi]),
                .best_vol_in  (tok_vol[gi]),
                .ctrl_out     (tok_ctrl[gi+1]),
                .best_id_out  (tok_id[gi+1]),
                .best_vol_out (tok_vol[gi+1])
            );
        end
    endgenerate

    assign fin = tok_ctrl[TABLE_DEPTH];

    // result of the token leaving the last cell
    always_comb
    begin
        fin_status = ST_NONE;
        fin_id     = '0;
        fin_vol    = '0;
        fin_notify = 1'b0;
        case (fin.op)
            REQ_LOAD:
            begin
                fin_status = fin.status;
                if (fin.status == ST_OK)
                begin
                    fin_id = key_id_reg;
                end
            end
            REQ_UPDATE:
            begin
                if (fin.found)
                begin
                    fin_status = ST_OK;
                    fin_id     = key_id_reg;
                    fin_notify = 1'b1;
                end
            end
            REQ_READ:
            begin
                if (fin.found)
                begin
                    fin_status = ST_OK;
                    fin_id     = key_id_reg;
                    fin_vol    = tok_vol[TABLE_DEPTH];
                end
            end
            REQ_MOST, REQ_BEST:
            begin
                if (fin.found)
                begin
                    fin_status = ST_OK;
                    fin_id     = tok_id[TABLE_DEPTH];
                    fin_vol    = tok_vol[TABLE_DEPTH];
                end
            end
            default:
            begin
                fin_status = ST_NONE;
            end
        endcase
    end

    always_comb
    begin
        bin_count_next   = bin_count_reg;
        busy_next        = busy_reg;
        key_id_next      = key_id_reg;
        key_vol_next     = key_vol_reg;
        launch_next      = '0;
        hold_valid_next  = hold_valid_reg;
        hold_status_next = hold_status_reg;
        hold_id_next     = hold_id_reg;
        hold_vol_next    = hold_vol_reg;
        hold_notify_next = hold_notify_reg;
        out_valid_next   = out_valid_reg && !rsp_ch.ready;
        out_status_next  = out_status_reg;
        out_id_next      = out_id_reg;
        out_vol_next     = out_vol_reg;
        out_notify_next  = out_notify_reg;

        if (req_accept)
        begin
            busy_next         = 1'b1;
            key_id_next       = req_ch.box_id;
            key_vol_next      = req_ch.volume;
            launch_next.valid = 1'b1;
            launch_next.op    = req_ch.req_type;
            launch_next.excl  = req_ch.exclude_enable;
            launch_next.found = 1'b0;
            if (req_ch.box_id == '0)
            begin
                launch_next.status = ST_ZERO;
            end
            else if (bin_count_reg >= DEPTH_CNT)
            begin
                launch_next.status = ST_FULL;
            end
            else
            begin
                launch_next.status  = ST_OK;
                launch_next.do_load = (req_ch.req_type == REQ_LOAD);
            end
        end

        if (fin.valid)
        begin
            if (fin.op == REQ_LOAD && fin.do_load)
            begin
                bin_count_next = bin_count_reg + 1'b1;
            end
            if (out_free)
            begin
                out_valid_next  = 1'b1;
                out_status_next = fin_status;
                out_id_next     = fin_id;
                out_vol_next    = fin_vol;
                out_notify_next = fin_notify;
                busy_next       = 1'b0;
            end
            else
            begin
                hold_valid_next  = 1'b1;
                hold_status_next = fin_status;
                hold_id_next     = fin_id;
                hold_vol_next    = fin_vol;
                hold_notify_next = fin_notify;
            end
        end
        else if (hold_valid_reg && out_free)
        begin
            out_valid_next  = 1'b1;
            out_status_next = hold_status_reg;
            out_id_next     = hold_id_reg;
            out_vol_next    = hold_vol_reg;
            out_notify_next = hold_notify_reg;
            hold_valid_next = 1'b0;
            busy_next       = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bin_count_reg  <= '0;
            busy_reg       <= 1'b0;
            launch_reg     <= '0;
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            bin_count_reg  <= bin_count_next;
            busy_reg       <= busy_next;
            launch_reg     <= launch_next;
            hold_valid_reg <= hold_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_id_reg      <= key_id_next;
        key_vol_reg     <= key_vol_next;
        hold_status_reg <= hold_status_next;
        hold_id_reg     <= hold_id_next;
        hold_vol_reg    <= hold_vol_next;
        hold_notify_reg <= hold_notify_next;
        out_status_reg  <= out_status_next;
        out_id_reg      <= out_id_next;
        out_vol_reg     <= out_vol_next;
        out_notify_reg  <= out_notify_next;
    end

    assign rsp_ch.valid         = out_valid_reg;
    assign rsp_ch.status        = out_status_reg;
    assign rsp_ch.result_id     = out_id_reg;
    assign rsp_ch.result_volume = out_vol_reg;
    assign rsp_ch.notify_store  = out_notify_reg;

    a_launch_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        req_accept |=> launch_reg.valid)
        else $error("request accepted but no token launched");

    a_token_only_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
        fin.valid |-> busy_reg)
        else $error("token left the chain while idle");

    a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        bin_count_reg <= DEPTH_CNT)
        else $error("bin count beyond table depth");

    a_notify_means_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_notify_reg) |-> (out_status_reg == ST_OK))
        else $error("store notification on a failed request");

    a_hold_not_busy_free: assert property (@(posedge clk) disable iff (!rst_n)
        hold_valid_reg |-> (busy_reg && out_valid_reg))
        else $error("held result without pending output");

endmodule
